### rtl/ir_pdfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance frame encoder package
// Shared widths, codes, configuration and pulse pair types.
// ----------------------------------------------------------------------------
package ir_pdfe_pkg;

   // Default tick rate per ten microseconds.
   localparam int TicksPerTenUsDefault = 10;

   // Largest tick count that fits the result fields.
   localparam int MaxTicks = 32767;

   // Widths fixed by the field definitions.
   localparam int WordW  = 32;
   localparam int UsW    = 16;
   localparam int TickW  = 15;
   localparam int CountW = 6;
   localparam int CsrIdxW = 3;

   // Exact divide by ten for 16-bit values: (x * 52429) >> 19.
   localparam int RecipTen  = 52429;
   localparam int RecipShift = 19;
   localparam int QuoW      = 13;

   // Frame building modes.
   typedef enum logic [1:0] {
      MODE_PLAIN    = 2'd0,
      MODE_INVERTED = 2'd1,
      MODE_REPEATED = 2'd2,
      MODE_CHECKSUM = 2'd3
   } frame_mode_type;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_MODE   = 3'd0,
      CSR_BIT_COUNT    = 3'd1,
      CSR_START_TIMING = 3'd2,
      CSR_ONE_TIMING   = 3'd3,
      CSR_ZERO_TIMING  = 3'd4,
      CSR_STOP_MARK    = 3'd5
   } csr_index_type;

   // Pulse timing settings used by the sequencer.
   typedef struct packed {
      logic [WordW-1:0] start_timing;
      logic [WordW-1:0] one_timing;
      logic [WordW-1:0] zero_timing;
      logic [UsW-1:0]   stop_mark;
   } timing_type;

   // One pulse pair in microseconds on its way to tick conversion.
   typedef struct packed {
      logic [UsW-1:0] mark_us;
      logic [UsW-1:0] space_us;
      logic           last;
   } pair_type;

endpackage
`default_nettype wire

### rtl/ir_pdfe_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance frame builder
// Forms the 32-bit code word from address and command, or passes a raw code.
// ----------------------------------------------------------------------------
module ir_pdfe_framer
   import ir_pdfe_pkg::*;
(
   input  wire logic                 kind,
   input  wire logic [UsW-1:0]       address,
   input  wire logic [UsW-1:0]       command,
   input  wire logic [WordW-1:0]     raw_code,
   input  wire frame_mode_type       frame_mode,
   output      logic [WordW-1:0]     frame_word
);

   logic [WordW-1:0] addr_w;
   logic [WordW-1:0] cmd_w;
   logic [WordW-1:0] na_w;
   logic [WordW-1:0] nc_w;
   logic [3:0]       nib_sum;
   logic [WordW-1:0] built;

   assign addr_w = {16'd0, address};
   assign cmd_w  = {16'd0, command};
   assign na_w   = {24'd0, ~address[7:0]};
   assign nc_w   = {24'd0, ~command[7:0]};

   // Checksum is the low nibble of the sum of six nibbles; carries drop out.
   assign nib_sum = address[3:0] + address[7:4] + command[15:12]
                  + command[11:8] + command[7:4] + command[3:0];

   // Every shifted term is cut to 32 bits and overlapping terms are ORed.
   always_comb begin
      case (frame_mode)
         MODE_PLAIN:    built = (addr_w << 8) | cmd_w;
         MODE_INVERTED: built = (addr_w << 24) | (na_w << 16) | (cmd_w << 8) | nc_w;
         MODE_REPEATED: built = (addr_w << 24) | (addr_w << 16) | (cmd_w << 8) | nc_w;
         MODE_CHECKSUM: built = (addr_w << 20) | (cmd_w << 4) | {28'd0, nib_sum};
         default:       built = (addr_w << 8) | cmd_w;
      endcase
   end

   assign frame_word = kind ? raw_code : built;

endmodule
`default_nettype wire

### rtl/ir_pdfe_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance pulse sequencer
// Shifts code bits out one per unstalled cycle; emits start, bit and stop pairs.
// ----------------------------------------------------------------------------
module ir_pdfe_sequencer
   import ir_pdfe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic [WordW-1:0]   word,
   input  wire logic [CountW-1:0]  bit_count,
   input  wire timing_type         timing,
   input  wire logic               advance,
   output      logic               idle,
   output      logic               pair_valid,
   output      pair_type           pair
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_BITS  = 4'b0100,
      ST_STOP  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [WordW-1:0]   shift_ff, shift_in;
   logic [CountW-1:0]  left_ff, left_in;
   logic [CountW-1:0]  count_sat;
   logic [CountW-1:0]  align;
   logic               has_stop;
   logic [WordW-1:0]   bit_timing;

   assign has_stop = (timing.stop_mark != '0);

   // Counts above the word width send the whole word.
   assign count_sat = (bit_count > CountW'(WordW)) ? CountW'(WordW) : bit_count;

   // Put the first bit to send at the top of the shift register.
   assign align = CountW'(WordW) - count_sat;

   assign bit_timing = shift_ff[WordW-1] ? timing.one_timing : timing.zero_timing;

   assign idle       = (state_ff == ST_IDLE);
   assign pair_valid = !idle;

   // Pair shown for the current phase.
   always_comb begin
      pair = '0;
      case (state_ff)
         ST_START: begin
            pair.mark_us  = timing.start_timing[WordW-1:UsW];
            pair.space_us = timing.start_timing[UsW-1:0];
            pair.last     = (left_ff == '0) && !has_stop;
         end
         ST_BITS: begin
            pair.mark_us  = bit_timing[WordW-1:UsW];
            pair.space_us = bit_timing[UsW-1:0];
            pair.last     = (left_ff == CountW'(1)) && !has_stop;
         end
         ST_STOP: begin
            pair.mark_us  = timing.stop_mark;
            pair.space_us = '0;
            pair.last     = 1'b1;
         end
         default: begin
            pair = '0;
         end
      endcase
   end

   // Phase sequencing and the serial bit shifter.
   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_START;
               shift_in = word << align;
               left_in  = count_sat;
            end
         end
         ST_START: begin
            if (advance) begin
               if (left_ff != '0) begin
                  state_in = ST_BITS;
               end else if (has_stop) begin
                  state_in = ST_STOP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BITS: begin
            if (advance) begin
               shift_in = {shift_ff[WordW-2:0], 1'b0};
               left_in  = left_ff - CountW'(1);
               if (left_ff == CountW'(1)) begin
                  state_in = has_stop ? ST_STOP : ST_IDLE;
               end
            end
         end
         ST_STOP: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule
`default_nettype wire

### rtl/ir_pdfe_ticks.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance tick converter
// Three-stage pipeline: divide by ten, scale to ticks, saturate into the output.
// ----------------------------------------------------------------------------
module ir_pdfe_ticks
   import ir_pdfe_pkg::*;
#(
   parameter int TICKS_PER_TEN_US = TicksPerTenUsDefault
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pair_valid,
   input  wire pair_type           pair,
   output      logic               advance,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [TickW-1:0]   rsp_mark_ticks,
   output      logic [TickW-1:0]   rsp_space_ticks,
   output      logic               rsp_is_last
);

   localparam int ScaleW = $clog2(TICKS_PER_TEN_US + 1);
   localparam int RawW   = QuoW + ScaleW;
   localparam int ProdW  = (RawW > 16) ? RawW : 16;
   localparam int RecW   = 2 * UsW;

   localparam logic [UsW-1:0]    RecipK = UsW'(RecipTen);
   localparam logic [ScaleW-1:0] ScaleK = ScaleW'(TICKS_PER_TEN_US);
   localparam logic [ProdW-1:0]  SatK   = ProdW'(MaxTicks);

   logic              v1_ff, v2_ff, out_v_ff;
   logic [RecW-1:0]   mark_rec_ff, space_rec_ff;
   logic              last1_ff, last2_ff, last_out_ff;
   logic [ProdW-1:0]  mark_raw_ff, space_raw_ff;
   logic [QuoW-1:0]   mark_quo, space_quo;
   logic [TickW-1:0]  mark_out_ff, space_out_ff;

   // The whole pipeline moves unless a result waits on a stalled output.
   assign advance = !out_v_ff || !rsp_stall;

   assign mark_quo  = mark_rec_ff[RecipShift +: QuoW];
   assign space_quo = space_rec_ff[RecipShift +: QuoW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= pair_valid;
         v2_ff    <= v1_ff;
         out_v_ff <= v2_ff;
      end
   end

   // Stage one multiplies by the reciprocal of ten.
   always_ff @(posedge clock) begin
      if (advance) begin
         mark_rec_ff  <= RecW'(pair.mark_us) * RecW'(RecipK);
         space_rec_ff <= RecW'(pair.space_us) * RecW'(RecipK);
         last1_ff     <= pair.last;
      end
   end

   // Stage two scales the whole tens of microseconds to ticks.
   always_ff @(posedge clock) begin
      if (advance) begin
         mark_raw_ff  <= ProdW'(mark_quo) * ProdW'(ScaleK);
         space_raw_ff <= ProdW'(space_quo) * ProdW'(ScaleK);
         last2_ff     <= last1_ff;
      end
   end

   // Stage three saturates into the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         mark_out_ff  <= (mark_raw_ff > SatK) ? TickW'(MaxTicks) : mark_raw_ff[TickW-1:0];
         space_out_ff <= (space_raw_ff > SatK) ? TickW'(MaxTicks) : space_raw_ff[TickW-1:0];
         last_out_ff  <= last2_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_mark_ticks  = mark_out_ff;
   assign rsp_space_ticks = space_out_ff;
   assign rsp_is_last     = last_out_ff;

endmodule
`default_nettype wire

### rtl/ir_pulse_distance_frame_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance frame encoder
// Turns one request into the mark/space pulse pairs of an infrared frame.
// ----------------------------------------------------------------------------
// Each accepted item produces a start pair, one pair per code bit (most
// significant first, bit_count bits, at most 32) and a stop pair when a stop
// mark is set, so 1 to 34 results with the final one flagged by rsp_is_last.
// The sequencer sends one pair per cycle while the output is not stalled,
// from a serial shift register of the code word, and the next item is taken
// in the cycle after its last pair leaves the sequencer; the results of an
// item reach the output through the tick conversion pipeline, and any output
// stall holds the whole pipeline and the sequencer. Durations are converted as
// (us / 10) * TICKS_PER_TEN_US and saturated at 32767 ticks. The
// configuration port is always ready and should only be written while idle.
module ir_pulse_distance_frame_encoder_top
   import ir_pdfe_pkg::*;
#(
   parameter int TICKS_PER_TEN_US = TicksPerTenUsDefault
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_kind,
   input  wire logic [UsW-1:0]      req_address,
   input  wire logic [UsW-1:0]      req_command,
   input  wire logic [WordW-1:0]    req_raw_code,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [TickW-1:0]    rsp_mark_ticks,
   output      logic [TickW-1:0]    rsp_space_ticks,
   output      logic                rsp_is_last,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [WordW-1:0]    csr_data
);

   frame_mode_type      frame_mode_ff;
   logic [CountW-1:0]   bit_count_ff;
   timing_type          timing_ff;
   logic [WordW-1:0]    frame_word;
   logic                seq_idle;
   logic                pair_valid;
   pair_type            pair;
   logic                advance;
   logic                load;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= MODE_PLAIN;
         bit_count_ff  <= CountW'(WordW);
         timing_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_MODE:   frame_mode_ff <= frame_mode_type'(csr_data[1:0]);
            CSR_BIT_COUNT:    bit_count_ff <= csr_data[CountW-1:0];
            CSR_START_TIMING: timing_ff.start_timing <= csr_data;
            CSR_ONE_TIMING:   timing_ff.one_timing <= csr_data;
            CSR_ZERO_TIMING:  timing_ff.zero_timing <= csr_data;
            CSR_STOP_MARK:    timing_ff.stop_mark <= csr_data[UsW-1:0];
            default:          ;
         endcase
      end
   end

   // A new item is taken only while the sequencer is idle.
   assign req_stall = !seq_idle;
   assign load      = req_valid && !req_stall;

   ir_pdfe_framer u_framer (
      .kind       (req_kind),
      .address    (req_address),
      .command    (req_command),
      .raw_code   (req_raw_code),
      .frame_mode (frame_mode_ff),
      .frame_word (frame_word)
   );

   ir_pdfe_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .word       (frame_word),
      .bit_count  (bit_count_ff),
      .timing     (timing_ff),
      .advance    (advance),
      .idle       (seq_idle),
      .pair_valid (pair_valid),
      .pair       (pair)
   );

   ir_pdfe_ticks #(
      .TICKS_PER_TEN_US (TICKS_PER_TEN_US)
   ) u_ticks (
      .clock           (clock),
      .reset           (reset),
      .pair_valid      (pair_valid),
      .pair            (pair),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mark_ticks  (rsp_mark_ticks),
      .rsp_space_ticks (rsp_space_ticks),
      .rsp_is_last     (rsp_is_last)
   );

endmodule
`default_nettype wire

### rtl/ir_pdfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance encoder port checker
// Watches the top-level ports over time and flags handshake or flow slips.
// ----------------------------------------------------------------------------
module ir_pdfe_checker
   import ir_pdfe_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [TickW-1:0]  rsp_mark_ticks,
   input wire logic [TickW-1:0]  rsp_space_ticks,
   input wire logic              rsp_is_last
);

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mark_ticks)
         && $stable(rsp_space_ticks) && $stable(rsp_is_last)))
      else $error("stalled result changed");

   // An accepted item keeps the block busy for at least its start pair.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // No result can show while the pipeline is still empty after reset.
   assert property (@(posedge clock) $fell(reset) |-> !rsp_valid [*3])
      else $error("result appeared without a source");

endmodule

bind ir_pulse_distance_frame_encoder_top ir_pdfe_checker u_ir_pdfe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_mark_ticks  (rsp_mark_ticks),
   .rsp_space_ticks (rsp_space_ticks),
   .rsp_is_last     (rsp_is_last)
);
`default_nettype wire

### dv/tb_ir_pulse_distance_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance frame encoder testbench
// A queue-fed driver offers requests with random gaps. A predictor turns each
// accepted request into the pulse pairs it should produce. A monitor stalls at
// random and compares every pulse pair with the oldest prediction. The encoder
// is reprogrammed between batches of requests, and only while it is idle.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_encoder_top;
   import ir_pdfe_pkg::*;

   localparam int TicksPerTenUs = TicksPerTenUsDefault;
   localparam int UsPerStep = 10;
   localparam int MaxBits = WordW;
   localparam int NumRegs = 6;
   localparam logic [CsrIdxW-1:0] CsrUnmapped = 3'd7;
   localparam logic KindFramed = 1'b0;
   localparam logic KindRaw = 1'b1;
   localparam int MaxGap = 19;
   localparam int LongHoldCycles = 400;
   localparam int SettleCycles = 8;
   localparam int WatchdogLimit = 5000;
   localparam int RandomPhases = 10;
   localparam int ItemsPerPhase = 21;
   localparam int MaxReports = 10;

   typedef struct {
      logic             kind;
      logic [UsW-1:0]   address;
      logic [UsW-1:0]   command;
      logic [WordW-1:0] raw_code;
   } request_type;

   typedef struct {
      logic [TickW-1:0] mark_ticks;
      logic [TickW-1:0] space_ticks;
      logic             is_last;
   } pulse_pair_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = 1'b0;
   logic [UsW-1:0]      req_address = '0;
   logic [UsW-1:0]      req_command = '0;
   logic [WordW-1:0]    req_raw_code = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TickW-1:0]    rsp_mark_ticks;
   logic [TickW-1:0]    rsp_space_ticks;
   logic                rsp_is_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [WordW-1:0]    csr_data = '0;

   // Mirror of the encoder settings, matching the reset values.
   frame_mode_type      cfg_mode = MODE_PLAIN;
   logic [CountW-1:0]   cfg_bits = 6'd32;
   logic [WordW-1:0]    cfg_start = '0;
   logic [WordW-1:0]    cfg_one = '0;
   logic [WordW-1:0]    cfg_zero = '0;
   logic [UsW-1:0]      cfg_stop = '0;

   request_type         pending_requests[$];
   request_type         current_request;
   pulse_pair_type      pulse_pairs_due[$];
   pulse_pair_type      due_pair;
   int                  failures = 0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   bit                  send_dense = 1'b0;
   bit                  recv_dense = 1'b0;
   bit                  offering;
   int                  holds_asked = 0;
   int                  holds_granted = 0;
   int                  quiet_cycles = 0;

   ir_pulse_distance_frame_encoder_top #(
      .TICKS_PER_TEN_US (TicksPerTenUs)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_address     (req_address),
      .req_command     (req_command),
      .req_raw_code    (req_raw_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mark_ticks  (rsp_mark_ticks),
      .rsp_space_ticks (rsp_space_ticks),
      .rsp_is_last     (rsp_is_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Microseconds to ticks: whole tens of microseconds, saturated.
   function automatic logic [TickW-1:0] us_to_ticks(logic [UsW-1:0] us);
      int unsigned ticks;
      ticks = (32'(us) / UsPerStep) * TicksPerTenUs;
      return (ticks > MaxTicks) ? TickW'(MaxTicks) : TickW'(ticks);
   endfunction

   // Code word of a request under the current frame mode.
   function automatic logic [WordW-1:0] frame_word_for(request_type r);
      logic [WordW-1:0] addr;
      logic [WordW-1:0] cmd;
      logic [7:0]       addr_low_inv;
      logic [7:0]       cmd_low_inv;
      logic [6:0]       nibble_sum;
      if (r.kind == KindRaw) begin
         return r.raw_code;
      end
      addr = {16'b0, r.address};
      cmd = {16'b0, r.command};
      addr_low_inv = ~r.address[7:0];
      cmd_low_inv = ~r.command[7:0];
      nibble_sum = 7'(r.address[3:0]) + 7'(r.address[7:4]) + 7'(r.command[15:12])
                 + 7'(r.command[11:8]) + 7'(r.command[7:4]) + 7'(r.command[3:0]);
      case (cfg_mode)
         MODE_PLAIN: begin
            return (addr << 8) | cmd;
         end
         MODE_INVERTED: begin
            return (addr << 24) | ({24'b0, addr_low_inv} << 16) | (cmd << 8)
                 | {24'b0, cmd_low_inv};
         end
         MODE_REPEATED: begin
            return (addr << 24) | (addr << 16) | (cmd << 8) | {24'b0, cmd_low_inv};
         end
         default: begin
            return (addr << 20) | (cmd << 4) | {28'b0, nibble_sum[3:0]};
         end
      endcase
   endfunction

   function automatic void expect_pair(logic [UsW-1:0] mark_us, logic [UsW-1:0] space_us,
                                       logic last);
      pulse_pair_type pair;
      pair.mark_ticks = us_to_ticks(mark_us);
      pair.space_ticks = us_to_ticks(space_us);
      pair.is_last = last;
      pulse_pairs_due.push_back(pair);
   endfunction

   // Start pair, one pair per code bit from the top down, then the stop mark.
   function automatic void encode_request(request_type r);
      logic [WordW-1:0] word;
      logic [WordW-1:0] timing;
      int               bits;
      bit               has_stop;
      word = frame_word_for(r);
      bits = (cfg_bits > MaxBits) ? MaxBits : int'(cfg_bits);
      has_stop = (cfg_stop != '0);
      expect_pair(cfg_start[31:16], cfg_start[15:0], (bits == 0) && !has_stop);
      for (int b = bits - 1; b >= 0; b--) begin
         timing = word[b] ? cfg_one : cfg_zero;
         expect_pair(timing[31:16], timing[15:0], (b == 0) && !has_stop);
      end
      if (has_stop) begin
         expect_pair(cfg_stop, '0, 1'b1);
      end
   endfunction

   function automatic logic [WordW-1:0] draw_timing();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom();
      end
      return {16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000))};
   endfunction

   task automatic queue_request(logic kind, logic [UsW-1:0] address, logic [UsW-1:0] command,
                                logic [WordW-1:0] raw_code);
      request_type r;
      r.kind = kind;
      r.address = address;
      r.command = command;
      r.raw_code = raw_code;
      pending_requests.push_back(r);
   endtask

   // Wait until every request has gone in and every pulse pair has come out.
   task automatic drain_encoder();
      while (pending_requests.size() > 0 || req_valid || pulse_pairs_due.size() > 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Write all six registers back to back, optionally followed by an unmapped index.
   task automatic program_encoder(frame_mode_type mode, logic [CountW-1:0] bits,
                                  logic [WordW-1:0] start, logic [WordW-1:0] one,
                                  logic [WordW-1:0] zero, logic [UsW-1:0] stop,
                                  bit with_unmapped);
      logic [WordW-1:0] value [NumRegs];
      int               writes;
      value[CSR_FRAME_MODE] = WordW'(mode);
      value[CSR_BIT_COUNT] = WordW'(bits);
      value[CSR_START_TIMING] = start;
      value[CSR_ONE_TIMING] = one;
      value[CSR_ZERO_TIMING] = zero;
      value[CSR_STOP_MARK] = WordW'(stop);
      writes = with_unmapped ? NumRegs + 1 : NumRegs;
      @(posedge clock);
      for (int r = 0; r < writes; r++) begin
         csr_valid <= 1'b1;
         csr_index <= (r < NumRegs) ? CsrIdxW'(r) : CsrUnmapped;
         csr_data <= (r < NumRegs) ? value[r] : '1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_mode = mode;
      cfg_bits = bits;
      cfg_start = start;
      cfg_one = one;
      cfg_zero = zero;
      cfg_stop = stop;
      @(negedge clock);
   endtask

   // Request driver: predicts on acceptance, then idles for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_valid;
         if (req_valid && !req_stall) begin
            encode_request(current_request);
            offering = 1'b0;
            if ($urandom_range(0, 31) == 0) begin
               send_dense = !send_dense;
            end
            send_gap = send_dense ? 0 : $urandom_range(0, MaxGap);
         end else if (!offering && send_gap > 0) begin
            send_gap--;
         end
         if (!offering && send_gap == 0 && pending_requests.size() > 0) begin
            current_request = pending_requests.pop_front();
            req_kind <= current_request.kind;
            req_address <= current_request.address;
            req_command <= current_request.command;
            req_raw_code <= current_request.raw_code;
            offering = 1'b1;
         end
         req_valid <= offering;
      end
   end

   // Pulse pair monitor: checks each accepted item and draws its own stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pulse_pairs_due.size() == 0) begin
               failures++;
               if (failures <= MaxReports) begin
                  $display("Unexpected pulse pair: mark %0d space %0d last %0b",
                           rsp_mark_ticks, rsp_space_ticks, rsp_is_last);
               end
            end else begin
               due_pair = pulse_pairs_due.pop_front();
               if (rsp_mark_ticks !== due_pair.mark_ticks
                   || rsp_space_ticks !== due_pair.space_ticks
                   || rsp_is_last !== due_pair.is_last) begin
                  failures++;
                  if (failures <= MaxReports) begin
                     $display("Pulse pair mismatch: expected mark %0d space %0d last %0b, %s",
                              due_pair.mark_ticks, due_pair.space_ticks, due_pair.is_last,
                              $sformatf("got mark %0d space %0d last %0b", rsp_mark_ticks,
                                        rsp_space_ticks, rsp_is_last));
                  end
               end
            end
            if ($urandom_range(0, 31) == 0) begin
               recv_dense = !recv_dense;
            end
            stall_left = recv_dense ? 0 : $urandom_range(0, MaxGap);
         end
         // A long hold-off lets the encoder fill up and stall its request side.
         if (holds_granted != holds_asked) begin
            holds_granted++;
            stall_left = LongHoldCycles;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which no channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      frame_mode_type    mode;
      logic [CountW-1:0] bits;
      logic [UsW-1:0]    stop;
      int                pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: 32 bits, zero timings, no stop mark.
      queue_request(KindFramed, 16'hFFFF, 16'hFFFF, 32'h0);
      queue_request(KindRaw, 16'h0, 16'h0, 32'hFFFF_FFFF);
      drain_encoder();

      // Classic timings in every frame mode.
      program_encoder(MODE_PLAIN, 6'd32, {16'd9000, 16'd4500}, {16'd560, 16'd1690},
                      {16'd560, 16'd560}, 16'd560, 1'b1);
      queue_request(KindFramed, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      queue_request(KindFramed, 16'h0000, 16'hFFFF, 32'h0);
      queue_request(KindRaw, 16'hFFFF, 16'hFFFF, 32'h8000_0001);
      queue_request(KindRaw, 16'hFFFF, 16'hFFFF, 32'h0);
      drain_encoder();
      program_encoder(MODE_INVERTED, 6'd32, {16'd9000, 16'd4500}, {16'd560, 16'd1690},
                      {16'd560, 16'd560}, 16'd560, 1'b0);
      queue_request(KindFramed, 16'h00FF, 16'hFF00, 32'h0);
      queue_request(KindFramed, 16'h1234, 16'hABCD, 32'h0);
      drain_encoder();
      program_encoder(MODE_REPEATED, 6'd32, {16'd9000, 16'd4500}, {16'd560, 16'd1690},
                      {16'd560, 16'd560}, 16'd560, 1'b0);
      queue_request(KindFramed, 16'hFFFF, 16'hFFFF, 32'h0);
      queue_request(KindFramed, 16'h00A5, 16'h5A00, 32'h0);
      drain_encoder();
      program_encoder(MODE_CHECKSUM, 6'd32, {16'd9000, 16'd4500}, {16'd560, 16'd1690},
                      {16'd560, 16'd560}, 16'd560, 1'b0);
      queue_request(KindFramed, 16'hFFFF, 16'hFFFF, 32'h0);
      queue_request(KindFramed, 16'h0FFF, 16'h0001, 32'h0);
      queue_request(KindRaw, 16'h1234, 16'h5678, 32'hDEAD_BEEF);
      drain_encoder();

      // Zero bit count without a stop mark: the start pair alone ends the frame.
      program_encoder(MODE_PLAIN, 6'd0, {16'd2400, 16'd600}, {16'd1200, 16'd600},
                      {16'd600, 16'd600}, 16'd0, 1'b0);
      queue_request(KindFramed, 16'hFFFF, 16'hFFFF, 32'h0);
      queue_request(KindRaw, 16'h0, 16'h0, 32'hFFFF_FFFF);
      drain_encoder();

      // Bit count above 32 and saturating durations everywhere.
      program_encoder(MODE_CHECKSUM, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      16'hFFFF, 1'b0);
      queue_request(KindFramed, 16'hFFFF, 16'hFFFF, 32'h0);
      queue_request(KindRaw, 16'h0, 16'h0, 32'h5555_5555);
      drain_encoder();

      // One bit, durations around the ten microsecond step, a stop mark under one step.
      program_encoder(MODE_INVERTED, 6'd1, {16'd9, 16'd10}, {16'd19, 16'd20},
                      {16'd32769, 16'd32779}, 16'd9, 1'b0);
      queue_request(KindFramed, 16'h0001, 16'h0000, 32'h0);
      queue_request(KindRaw, 16'h0, 16'h0, 32'h0000_0001);

      // Random settings per batch; one batch runs against a long receiver hold-off.
      for (int p = 0; p < RandomPhases; p++) begin
         drain_encoder();
         mode = frame_mode_type'($urandom_range(0, 3));
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            bits = '0;
         end else if (pick == 1) begin
            bits = CountW'($urandom_range(MaxBits + 1, 63));
         end else begin
            bits = CountW'($urandom_range(1, MaxBits));
         end
         stop = ($urandom_range(0, 3) == 0) ? '0 : UsW'($urandom_range(1, 65535));
         program_encoder(mode, bits, draw_timing(), draw_timing(), draw_timing(), stop, 1'b0);
         if (p == 2) begin
            holds_asked++;
         end
         for (int i = 0; i < ItemsPerPhase; i++) begin
            queue_request(1'($urandom_range(0, 1)), UsW'($urandom()), UsW'($urandom()),
                          $urandom());
         end
      end
      drain_encoder();

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
